### src/affine3d_matrix_inverse_defines.svh
// Assertion macros shared by the affine inverse RTL
`ifndef AFFINE3D_MATRIX_INVERSE_DEFINES_SVH
`define AFFINE3D_MATRIX_INVERSE_DEFINES_SVH
`ifndef SYNTHESIS
`define A3DINV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define A3DINV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define A3DINV_ASSERT(lbl, clk, rstn, prop, msg)
`define A3DINV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/a3dinv_pkg.sv
// Types, constants and operand tables of the affine 4x4 inverse
`default_nettype none
package a3dinv_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int N_ELEM         = 9;
    localparam int FRT_STEPS      = 24;
    localparam int FRT_COF_STEPS  = 18;
    localparam logic [1:0] LAST_ROW = 2'd3;

    localparam logic [3:0] FRT_IDX_A [FRT_STEPS] = '{
        4'd4, 4'd7, 4'd7, 4'd1, 4'd1, 4'd4, 4'd5, 4'd8, 4'd8, 4'd2, 4'd2, 4'd5,
        4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2
    };
    localparam logic [3:0] FRT_IDX_B [FRT_STEPS] = '{
        4'd8, 4'd5, 4'd2, 4'd8, 4'd5, 4'd2, 4'd6, 4'd3, 4'd0, 4'd6, 4'd3, 4'd0,
        4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd1, 4'd0, 4'd0, 4'd3, 4'd3, 4'd6, 4'd6
    };

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DRAIN,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DSET,
        B_DIV,
        B_DSTORE,
        B_TMUL,
        B_TFIN,
        B_OUT
    } back_state_t;

endpackage
`default_nettype wire

### src/a3dinv_front.sv
// Front: accepts matrices, forms cofactors and determinant on one multiplier
`default_nettype none
module a3dinv_front #(
    parameter int DATA_WIDTH = a3dinv_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [DATA_WIDTH-1:0]        m_in [9],
    input  logic signed [DATA_WIDTH-1:0]        t_in [3],
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [1+(3*DATA_WIDTH+2)+3*DATA_WIDTH+9*(2*DATA_WIDTH+1)-1:0] q_data
);
    import a3dinv_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 2;
    localparam int PW = 2 * W + 2;
    localparam logic [4:0] COF_END  = 5'(FRT_COF_STEPS);
    localparam logic [4:0] LAST_STEP = 5'(FRT_STEPS - 1);

    front_state_t state_reg, state_next;
    logic signed [W-1:0]  hold_m_reg [9];
    logic signed [W-1:0]  hold_t_reg [3];
    logic                 hold_valid_reg;
    logic signed [W-1:0]  ma_reg [9];
    logic signed [W-1:0]  mb_reg [9];
    logic signed [W-1:0]  t_reg [3];
    logic signed [AW-1:0] adj_reg [9];
    logic signed [DW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_valid_reg;
    logic [4:0]           prod_step_reg;
    logic [4:0]           step_reg, step_next;
    logic                 in_fire, load;
    logic [3:0]           ia, ib;
    logic signed [W:0]    op_a, op_b;
    logic signed [AW-1:0] adj_sel;
    logic signed [DW-1:0] prod_ext, prod_add;

    assign in_ready = !hold_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign load     = (state_reg == F_IDLE) && hold_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (load) state_next = F_MUL;
            F_MUL:   if (step_reg == LAST_STEP) state_next = F_DRAIN;
            F_DRAIN: state_next = F_PUSH;
            F_PUSH:  if (q_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (state_reg == F_MUL)
        begin
            step_next = (step_reg == LAST_STEP) ? 5'd0 : step_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            step_reg       <= 5'd0;
            hold_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            prod_valid_reg <= (state_reg == F_MUL);
            if (in_fire)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // operand select: cofactor terms, then determinant as low and high halves
    always_comb
    begin
        ia      = FRT_IDX_A[step_reg];
        ib      = FRT_IDX_B[step_reg];
        adj_sel = adj_reg[ib];
        op_a    = {ma_reg[ia][W-1], ma_reg[ia]};
        if (step_reg < COF_END)
        begin
            op_b = {mb_reg[ib][W-1], mb_reg[ib]};
        end
        else if (!step_reg[0])
        begin
            op_b = {1'b0, adj_sel[W-1:0]};
        end
        else
        begin
            op_b = adj_sel[AW-1:W];
        end
    end

    always_comb
    begin
        prod_ext = {{(DW-PW){prod_reg[PW-1]}}, prod_reg};
        prod_add = prod_step_reg[0] ? (prod_ext <<< W) : prod_ext;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_m_reg <= m_in;
            hold_t_reg <= t_in;
        end
        if (load)
        begin
            ma_reg <= hold_m_reg;
            mb_reg <= hold_m_reg;
            t_reg  <= hold_t_reg;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= op_a * op_b;
        end
        prod_step_reg <= step_reg;
        if (prod_valid_reg)
        begin
            if (prod_step_reg < COF_END)
            begin
                if (!prod_step_reg[0])
                begin
                    acc_reg <= prod_ext;
                end
                else
                begin
                    adj_reg[prod_step_reg[4:1]] <= acc_reg[AW-1:0] - prod_reg[AW-1:0];
                end
            end
            else
            begin
                acc_reg <= ((prod_step_reg == COF_END) ? '0 : acc_reg) + prod_add;
            end
        end
    end

    assign q_valid = (state_reg == F_PUSH);
    assign q_data  = {(acc_reg == '0), acc_reg, t_reg[2], t_reg[1], t_reg[0],
                      adj_reg[8], adj_reg[7], adj_reg[6], adj_reg[5], adj_reg[4],
                      adj_reg[3], adj_reg[2], adj_reg[1], adj_reg[0]};

endmodule
`default_nettype wire

### src/a3dinv_fifo.sv
// Short request queue between front and back
`default_nettype none
`include "affine3d_matrix_inverse_defines.svh"
module a3dinv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = a3dinv_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import a3dinv_pkg::*;

    localparam int PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam logic [PTR-1:0] PTR_LAST = PTR'(DEPTH - 1);
    localparam logic [CW-1:0]  CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `A3DINV_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_reg <= CNT_FULL, "queue count over depth")
    `A3DINV_ASSERT(a_cnt_inc, clk, rst_n, push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1, "queue count missed a push")
    `A3DINV_ASSERT(a_cnt_dec, clk, rst_n, pop && !push |=> cnt_reg == $past(cnt_reg) - 1'b1, "queue count missed a pop")

endmodule
`default_nettype wire

### src/a3dinv_back.sv
// Back: divides cofactors by the determinant, forms translation, emits rows
`default_nettype none
`include "affine3d_matrix_inverse_defines.svh"
module a3dinv_back #(
    parameter int DATA_WIDTH = a3dinv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = a3dinv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [1+(3*DATA_WIDTH+2)+3*DATA_WIDTH+9*(2*DATA_WIDTH+1)-1:0] q_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   row,
    output logic signed [DATA_WIDTH-1:0] c0,
    output logic signed [DATA_WIDTH-1:0] c1,
    output logic signed [DATA_WIDTH-1:0] c2,
    output logic                         singular,
    output logic                         last
);
    import a3dinv_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int AW  = 2 * W + 1;
    localparam int DW  = 3 * W + 2;
    localparam int QW  = 1 + DW + 3 * W + 9 * AW;
    localparam int MW  = ((AW + 2 * F > DW + W) ? AW + 2 * F : DW + W) + 1;
    localparam int TW  = 2 * W + 2;
    localparam int NW  = TW + 1;
    localparam int BW  = $clog2(W);
    localparam logic [BW-1:0] BIT_LAST  = BW'(W - 1);
    localparam logic [3:0]    ELEM_LAST = 4'(N_ELEM - 1);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    back_state_t state_reg, state_next;

    logic signed [AW-1:0] adj_in [9];
    logic signed [W-1:0]  t_in [3];
    logic signed [DW-1:0] det_in;
    logic                 sing_in;

    logic signed [AW-1:0] adj_reg [9];
    logic signed [W-1:0]  t_reg [3];
    logic [DW-1:0]        det_mag_reg;
    logic                 det_neg_reg;
    logic                 sing_reg;
    logic signed [W-1:0]  inv_reg [9];
    logic signed [W-1:0]  tn_reg [3];

    logic [3:0]           elem_reg;
    logic [MW-1:0]        rem_reg, dv_reg;
    logic [W-1:0]         q_reg;
    logic [BW-1:0]        bit_reg;
    logic                 neg_reg, ovf_reg;

    logic [1:0]           tj_reg, tk_reg;
    logic                 tp_valid_reg;
    logic [1:0]           tp_j_reg, tp_k_reg;
    logic signed [2*W-1:0] tprod_reg;
    logic signed [TW-1:0] tacc_reg;
    logic                 fin_valid_reg;
    logic [1:0]           fin_j_reg;
    logic [1:0]           orow_reg;

    logic                 out_valid_reg, out_last_reg, out_sing_reg;
    logic [1:0]           out_row_reg;
    logic signed [W-1:0]  out_c0_reg, out_c1_reg, out_c2_reg;

    logic                 pop, load_out, tmul_end;
    logic signed [AW-1:0] cur_adj;
    logic [AW-1:0]        cur_mag;
    logic [MW-1:0]        nmag, dshift;
    logic                 ge;
    logic signed [W-1:0]  inv_sat;
    logic [3:0]           tidx;
    logic signed [TW-1:0] tsum;
    logic signed [NW-1:0] nacc, nshift;
    logic signed [W-1:0]  tn_sat;

    genvar g;
    generate
        for (g = 0; g < 9; g++)
        begin : g_adj
            assign adj_in[g] = q_data[g*AW +: AW];
        end
        for (g = 0; g < 3; g++)
        begin : g_t
            assign t_in[g] = q_data[9*AW + g*W +: W];
        end
    endgenerate
    assign det_in  = q_data[9*AW + 3*W +: DW];
    assign sing_in = q_data[QW-1];

    assign q_ready  = (state_reg == B_IDLE);
    assign pop      = q_valid && q_ready;
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
    assign tmul_end = (tj_reg == 2'd2) && (tk_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (pop) state_next = sing_in ? B_OUT : B_DSET;
            B_DSET:   state_next = B_DIV;
            B_DIV:    if (bit_reg == BIT_LAST) state_next = B_DSTORE;
            B_DSTORE: state_next = (elem_reg == ELEM_LAST) ? B_TMUL : B_DSET;
            B_TMUL:   if (tmul_end) state_next = B_TFIN;
            B_TFIN:   if (!tp_valid_reg && !fin_valid_reg) state_next = B_OUT;
            B_OUT:    if (load_out && orow_reg == LAST_ROW) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // divider setup, one quotient bit per step, then saturation
    always_comb
    begin
        cur_adj = adj_reg[elem_reg];
        cur_mag = cur_adj[AW-1] ? AW'(-cur_adj) : AW'(cur_adj);
        nmag    = MW'(cur_mag) << (2 * F);
        dshift  = MW'(det_mag_reg) << W;
        ge      = (rem_reg >= dv_reg);
        if (ovf_reg)
        begin
            inv_sat = neg_reg ? MINV : MAXV;
        end
        else if (neg_reg)
        begin
            inv_sat = (q_reg > MINV) ? MINV : -$signed(q_reg);
        end
        else
        begin
            inv_sat = q_reg[W-1] ? MAXV : $signed(q_reg);
        end
    end

    // translation: floor of negated sum over FRAC_BITS, saturated
    always_comb
    begin
        tidx   = 4'(tk_reg) * 4'd3 + 4'(tj_reg);
        tsum   = tacc_reg + {{(TW-2*W){tprod_reg[2*W-1]}}, tprod_reg};
        nacc   = -{tacc_reg[TW-1], tacc_reg};
        nshift = nacc >>> F;
        if (nshift > $signed({{(NW-W){MAXV[W-1]}}, MAXV}))
        begin
            tn_sat = MAXV;
        end
        else if (nshift < $signed({{(NW-W){MINV[W-1]}}, MINV}))
        begin
            tn_sat = MINV;
        end
        else
        begin
            tn_sat = nshift[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            elem_reg      <= 4'd0;
            bit_reg       <= '0;
            tj_reg        <= 2'd0;
            tk_reg        <= 2'd0;
            tp_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            orow_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tp_valid_reg  <= (state_reg == B_TMUL);
            fin_valid_reg <= tp_valid_reg && (tp_k_reg == 2'd2);
            if (pop)
            begin
                elem_reg <= 4'd0;
            end
            else if (state_reg == B_DSTORE)
            begin
                elem_reg <= elem_reg + 4'd1;
            end
            if (state_reg == B_DSET)
            begin
                bit_reg <= '0;
            end
            else if (state_reg == B_DIV)
            begin
                bit_reg <= bit_reg + 1'b1;
            end
            if (state_reg == B_TMUL)
            begin
                tk_reg <= (tk_reg == 2'd2) ? 2'd0 : tk_reg + 2'd1;
                if (tk_reg == 2'd2)
                begin
                    tj_reg <= (tj_reg == 2'd2) ? 2'd0 : tj_reg + 2'd1;
                end
            end
            if (load_out)
            begin
                orow_reg      <= orow_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            adj_reg     <= adj_in;
            t_reg       <= t_in;
            sing_reg    <= sing_in;
            det_neg_reg <= det_in[DW-1];
            det_mag_reg <= det_in[DW-1] ? DW'(-det_in) : DW'(det_in);
            if (sing_in)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    inv_reg[i] <= '0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    tn_reg[i] <= '0;
                end
            end
        end
        if (state_reg == B_DSET)
        begin
            rem_reg <= nmag;
            dv_reg  <= MW'(det_mag_reg) << (W - 1);
            neg_reg <= cur_adj[AW-1] ^ det_neg_reg;
            ovf_reg <= (nmag >= dshift);
            q_reg   <= '0;
        end
        if (state_reg == B_DIV)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dv_reg;
            end
            q_reg  <= {q_reg[W-2:0], ge};
            dv_reg <= dv_reg >> 1;
        end
        if (state_reg == B_DSTORE)
        begin
            inv_reg[elem_reg] <= inv_sat;
        end
        if (state_reg == B_TMUL)
        begin
            tprod_reg <= t_reg[tk_reg] * inv_reg[tidx];
        end
        tp_j_reg <= tj_reg;
        tp_k_reg <= tk_reg;
        if (tp_valid_reg)
        begin
            tacc_reg  <= (tp_k_reg == 2'd0) ?
                         {{(TW-2*W){tprod_reg[2*W-1]}}, tprod_reg} : tsum;
            fin_j_reg <= tp_j_reg;
        end
        if (fin_valid_reg)
        begin
            tn_reg[fin_j_reg] <= tn_sat;
        end
        if (load_out)
        begin
            out_row_reg  <= orow_reg;
            out_last_reg <= (orow_reg == LAST_ROW);
            out_sing_reg <= sing_reg;
            out_c0_reg   <= inv_reg[0];
            out_c1_reg   <= inv_reg[1];
            out_c2_reg   <= inv_reg[2];
            // advance rows toward the head
            for (int i = 0; i < 6; i++)
            begin
                inv_reg[i] <= inv_reg[i+3];
            end
            for (int i = 0; i < 3; i++)
            begin
                inv_reg[6+i] <= tn_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = out_row_reg;
    assign c0        = out_c0_reg;
    assign c1        = out_c1_reg;
    assign c2        = out_c2_reg;
    assign singular  = out_sing_reg;
    assign last      = out_last_reg;

    `A3DINV_ASSERT(a_no_div_singular, clk, rst_n, (state_reg == B_DIV) |-> !sing_reg, "dividing a singular matrix")
    `A3DINV_ASSERT(a_singular_zero, clk, rst_n, out_valid_reg && out_sing_reg |-> (out_c0_reg == '0) && (out_c1_reg == '0) && (out_c2_reg == '0), "singular row not zero")
    `A3DINV_ASSERT(a_last_row_idle, clk, rst_n, load_out && (orow_reg == LAST_ROW) |=> (state_reg == B_IDLE) && out_last_reg, "last row did not end the matrix")

endmodule
`default_nettype wire

### src/affine3d_matrix_inverse.sv
// Top level of the affine 4x4 matrix inverse
// Accepts one affine matrix (3x3 linear part and translation row, signed
// fixed point) per request and returns four rows: the three rows of the
// inverse linear part, then the new translation row, with last set on the
// fourth. The front forms the nine cofactors and the determinant on one
// shared multiplier and hands them to a two-entry queue, so a new matrix is
// taken while the previous one is still being worked. The back sets the
// rate: one shared restoring divider produces each of the nine inverse
// elements in turn, followed by nine translation products and four output
// rows. A singular matrix skips the divider. Results sit in an output
// register; a stalled consumer holds the back on its current row, and the
// queue and the front then absorb further matrices until the input stalls.
`default_nettype none
module affine3d_matrix_inverse #(
    parameter int DATA_WIDTH = a3dinv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = a3dinv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] r0c0,
    input  logic signed [DATA_WIDTH-1:0] r0c1,
    input  logic signed [DATA_WIDTH-1:0] r0c2,
    input  logic signed [DATA_WIDTH-1:0] r1c0,
    input  logic signed [DATA_WIDTH-1:0] r1c1,
    input  logic signed [DATA_WIDTH-1:0] r1c2,
    input  logic signed [DATA_WIDTH-1:0] r2c0,
    input  logic signed [DATA_WIDTH-1:0] r2c1,
    input  logic signed [DATA_WIDTH-1:0] r2c2,
    input  logic signed [DATA_WIDTH-1:0] tx,
    input  logic signed [DATA_WIDTH-1:0] ty,
    input  logic signed [DATA_WIDTH-1:0] tz,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   row,
    output logic signed [DATA_WIDTH-1:0] c0,
    output logic signed [DATA_WIDTH-1:0] c1,
    output logic signed [DATA_WIDTH-1:0] c2,
    output logic                         singular,
    output logic                         last
);
    import a3dinv_pkg::*;

    localparam int QW = 1 + (3 * DATA_WIDTH + 2) + 3 * DATA_WIDTH + 9 * (2 * DATA_WIDTH + 1);

    logic signed [DATA_WIDTH-1:0] m_arr [9];
    logic signed [DATA_WIDTH-1:0] t_arr [3];
    logic          fq_valid, fq_ready, bq_valid, bq_ready;
    logic [QW-1:0] fq_data, bq_data;

    assign m_arr[0] = r0c0;
    assign m_arr[1] = r0c1;
    assign m_arr[2] = r0c2;
    assign m_arr[3] = r1c0;
    assign m_arr[4] = r1c1;
    assign m_arr[5] = r1c2;
    assign m_arr[6] = r2c0;
    assign m_arr[7] = r2c1;
    assign m_arr[8] = r2c2;
    assign t_arr[0] = tx;
    assign t_arr[1] = ty;
    assign t_arr[2] = tz;

    a3dinv_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .m_in     (m_arr),
        .t_in     (t_arr),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    a3dinv_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (bq_data)
    );

    a3dinv_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_data    (bq_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row       (row),
        .c0        (c0),
        .c1        (c1),
        .c2        (c2),
        .singular  (singular),
        .last      (last)
    );

endmodule
`default_nettype wire
